[hw/rtl/prqs_pkg.sv]
`default_nettype none

package prqs_pkg;

    localparam int PRQS_MAX_PROCESSES = 16;
    localparam int PRQS_MEMORY_WORDS  = 65536;

    localparam int ACTION_W   = 2;
    localparam int SIZE_W     = 17;
    localparam int LEN_W      = 16;
    localparam int ID_W       = 8;
    localparam int BASE_OUT_W = 16;
    localparam int ERR_W      = 2;
    localparam int MODE_W     = 2;
    localparam int QUANTUM_W  = 16;
    localparam int SLICE_W    = 16;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 1;

    localparam logic [REG_W-1:0] REG_MODE    = 1'd0;
    localparam logic [REG_W-1:0] REG_QUANTUM = 1'd1;

    localparam logic [MODE_W-1:0]    MODE_RESET    = 2'd0;
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

    localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RR   = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_EXIT   = 2'd2
    } action_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_QUEUE_FULL = 2'd1,
        ERR_MEM_FULL   = 2'd2,
        ERR_EMPTY_EXIT = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_ROTATE,
        ST_HEAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
    } entry_t;

    typedef struct packed {
        logic latch_item;
        logic alloc;
        logic err_we;
        err_t err;
        logic set_switched;
        logic set_stopped;
        logic append;
        logic scan_init;
        logic scan_step;
        logic scan_last;
        logic slice_inc;
        logic slice_clr;
        logic rotate;
        logic pop;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        action_t act;
        logic    q_full;
        logic    mem_full;
        logic    cnt_zero;
        logic    cnt_multi;
        logic    slice_le;
        logic    sjf;
        logic    rr;
        logic    scan_hit;
        logic    scan_last;
        logic    out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/process_run_queue_scheduler_top.sv]
// A tick, an exit or a plain create passes ST_DECIDE, ST_HEAD and ST_OUT before its
// result is valid; a rotation adds ST_ROTATE; a shortest-job create adds ST_SCAN,
// one queue slot per cycle through the ring memory, and then ST_SCAN_LAST when the
// new job is not last. A new transaction is taken only once the result is loaded.
// Reset: queue empty, ids, allocator and slice counter zero, mode 0, quantum 4;
// the queue memory is not cleared and needs no clearing pass.
`default_nettype none

module process_run_queue_scheduler_top import prqs_pkg::*;
#(
    parameter int MAX_PROCESSES = PRQS_MAX_PROCESSES,
    parameter int MEMORY_WORDS  = PRQS_MEMORY_WORDS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [ACTION_W-1:0]   action,
    input  wire logic [SIZE_W-1:0]     program_size,
    input  wire logic [LEN_W-1:0]      job_length,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [ID_W-1:0]       running_id,
    output logic                       running_valid,
    output logic                       switched,
    output logic                       stopped,
    output logic      [ID_W-1:0]       new_id,
    output logic      [BASE_OUT_W-1:0] base_address,
    output logic      [ERR_W-1:0]      error,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [PDATA_W-1:0]    pwdata,
    output logic      [PDATA_W-1:0]    prdata,
    output logic                       pready
);

    logic [MODE_W-1:0]    mode;
    logic [QUANTUM_W-1:0] quantum;
    dp_cmd_t              cmd;
    dp_status_t           status;

    prqs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode),
        .quantum (quantum)
    );

    prqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    prqs_dp #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MEMORY_WORDS  (MEMORY_WORDS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .action        (action),
        .program_size  (program_size),
        .job_length    (job_length),
        .mode          (mode),
        .quantum       (quantum),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .running_id    (running_id),
        .running_valid (running_valid),
        .switched      (switched),
        .stopped       (stopped),
        .new_id        (new_id),
        .base_address  (base_address),
        .error         (error)
    );

    // One transaction in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a transaction is in flight");

    a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running_valid |-> running_id == '0)
        else $error("empty queue reports a running id");

    a_stop_empties: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stopped |-> !running_valid && !switched)
        else $error("stop reported with a process still queued");

    a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error != ERR_NONE) |-> !switched && !stopped && new_id == '0)
        else $error("failed transaction reports a state change");

endmodule

`default_nettype wire

[hw/rtl/prqs_cfg.sv]
`default_nettype none

module prqs_cfg import prqs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready,
    output logic      [MODE_W-1:0]    mode,
    output logic      [QUANTUM_W-1:0] quantum
);

    logic [MODE_W-1:0]    mode_reg;
    logic [MODE_W-1:0]    mode_next;
    logic [QUANTUM_W-1:0] quantum_reg;
    logic [QUANTUM_W-1:0] quantum_next;
    logic [REG_W-1:0]     reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        mode_next    = mode_reg;
        quantum_next = quantum_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MODE:    mode_next    = pwdata[MODE_W-1:0];
                REG_QUANTUM: quantum_next = pwdata[QUANTUM_W-1:0];
                default:     mode_next    = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE:    prdata = PDATA_W'(mode_reg);
            REG_QUANTUM: prdata = PDATA_W'(quantum_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            quantum_reg <= QUANTUM_RESET;
        end
        else
        begin
            mode_reg    <= mode_next;
            quantum_reg <= quantum_next;
        end
    end

    assign mode    = mode_reg;
    assign quantum = quantum_reg;

endmodule

`default_nettype wire

[hw/rtl/prqs_ctrl.sv]
`default_nettype none

module prqs_ctrl import prqs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.err    = ERR_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_HEAD;
                case (status.act)
                    ACT_CREATE:
                    begin
                        if (status.q_full)
                        begin
                            cmd.err_we = 1'b1;
                            cmd.err    = ERR_QUEUE_FULL;
                        end
                        else if (status.mem_full)
                        begin
                            cmd.err_we = 1'b1;
                            cmd.err    = ERR_MEM_FULL;
                        end
                        else
                        begin
                            cmd.alloc = 1'b1;
                            if (status.sjf && !status.cnt_zero)
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = ST_SCAN;
                            end
                            else
                                cmd.append = 1'b1;
                        end
                    end
                    ACT_TICK:
                    begin
                        if (status.rr && !status.cnt_zero)
                        begin
                            if (status.slice_le)
                                cmd.slice_inc = 1'b1;
                            else
                            begin
                                cmd.slice_clr = 1'b1;
                                if (status.cnt_multi)
                                    state_next = ST_ROTATE;
                            end
                        end
                    end
                    ACT_EXIT:
                    begin
                        if (status.cnt_zero)
                        begin
                            cmd.err_we = 1'b1;
                            cmd.err    = ERR_EMPTY_EXIT;
                        end
                        else
                        begin
                            cmd.pop          = 1'b1;
                            cmd.set_switched = status.cnt_multi;
                            cmd.set_stopped  = !status.cnt_multi;
                        end
                    end
                    default:
                        state_next = ST_HEAD;
                endcase
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = status.scan_hit ? ST_SCAN_LAST : ST_HEAD;
            end
            ST_SCAN_LAST:
            begin
                cmd.scan_last = 1'b1;
                state_next    = ST_HEAD;
            end
            ST_ROTATE:
            begin
                cmd.rotate       = 1'b1;
                cmd.set_switched = 1'b1;
                state_next       = ST_HEAD;
            end
            ST_HEAD:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/prqs_dp.sv]
`default_nettype none

module prqs_dp import prqs_pkg::*;
#(
    parameter int MAX_PROCESSES = PRQS_MAX_PROCESSES,
    parameter int MEMORY_WORDS  = PRQS_MEMORY_WORDS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [ACTION_W-1:0]   action,
    input  wire logic [SIZE_W-1:0]     program_size,
    input  wire logic [LEN_W-1:0]      job_length,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [QUANTUM_W-1:0]  quantum,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic      [ID_W-1:0]       running_id,
    output logic                       running_valid,
    output logic                       switched,
    output logic                       stopped,
    output logic      [ID_W-1:0]       new_id,
    output logic      [BASE_OUT_W-1:0] base_address,
    output logic      [ERR_W-1:0]      error
);

    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int PTR_W  = $clog2(MAX_PROCESSES);
    localparam int BASE_W = $clog2(MEMORY_WORDS + 1);
    localparam int SUM_W  = ((BASE_W > SIZE_W) ? BASE_W : SIZE_W) + 1;

    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_PROCESSES);
    localparam logic [CNT_W:0]   MAX_EXT   = (CNT_W + 1)'(MAX_PROCESSES);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(MAX_PROCESSES - 1);
    localparam logic [SUM_W-1:0] MEM_LIMIT = SUM_W'(MEMORY_WORDS);

    // Queue held as a ring: logical slot k lives at (head + k) mod depth
    entry_t mem [MAX_PROCESSES];
    entry_t rd_entry_reg;

    logic [ACTION_W-1:0] item_action_reg;
    logic [SIZE_W-1:0]   item_size_reg;
    logic [LEN_W-1:0]    item_key_reg;

    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [ID_W-1:0]    next_id_reg;
    logic [ID_W-1:0]    next_id_next;
    logic [BASE_W-1:0]  next_base_reg;
    logic [BASE_W-1:0]  next_base_next;
    logic [SLICE_W-1:0] slice_reg;
    logic [SLICE_W-1:0] slice_next;

    logic [CNT_W-1:0] idx_reg;
    logic             found_reg;
    entry_t           carry_reg;

    logic [ID_W-1:0]       res_new_id_reg;
    logic [BASE_OUT_W-1:0] res_base_reg;
    err_t                  res_err_reg;
    logic                  res_switched_reg;
    logic                  res_stopped_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ID_W-1:0]       out_running_id_reg;
    logic                  out_running_valid_reg;
    logic                  out_switched_reg;
    logic                  out_stopped_reg;
    logic [ID_W-1:0]       out_new_id_reg;
    logic [BASE_OUT_W-1:0] out_base_reg;
    logic [ERR_W-1:0]      out_error_reg;

    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] rd_off;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] tail_addr;
    logic [PTR_W-1:0] idx_addr;
    logic [PTR_W-1:0] head_inc;
    logic [SUM_W-1:0] base_ext;
    logic [SUM_W-1:0] alloc_sum;
    logic             scan_hit;
    logic             scan_last;
    logic             cnt_zero;
    entry_t           new_entry;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    entry_t           wr_data;

    function automatic logic [PTR_W-1:0] ring_addr(input logic [PTR_W-1:0] hd,
                                                    input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(hd) + (CNT_W + 1)'(off);
        if (sum >= MAX_EXT)
            sum = sum - MAX_EXT;
        return sum[PTR_W-1:0];
    endfunction

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign rd_off    = cmd.scan_step ? idx_inc : '0;
    assign rd_addr   = ring_addr(head_reg, rd_off);
    assign tail_addr = ring_addr(head_reg, count_reg);
    assign idx_addr  = ring_addr(head_reg, idx_reg);
    assign head_inc  = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
    assign base_ext  = SUM_W'(next_base_reg);
    assign alloc_sum = base_ext + SUM_W'(item_size_reg);
    assign cnt_zero  = (count_reg == '0);

    // Insert before the first longer job; everything from there ripples one slot on
    assign scan_hit  = found_reg || (rd_entry_reg.len > item_key_reg);
    assign scan_last = (idx_inc == count_reg);

    assign new_entry.id  = cmd.append ? next_id_reg : res_new_id_reg;
    assign new_entry.len = item_key_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = tail_addr;
        wr_data = new_entry;
        if (cmd.append)
            wr_en = 1'b1;
        else if (cmd.scan_step)
        begin
            wr_en   = scan_hit || scan_last;
            wr_addr = scan_hit ? idx_addr : tail_addr;
            wr_data = found_reg ? carry_reg : new_entry;
        end
        else if (cmd.scan_last)
        begin
            wr_en   = 1'b1;
            wr_data = carry_reg;
        end
        else if (cmd.rotate)
        begin
            wr_en   = 1'b1;
            wr_data = rd_entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_entry_reg <= mem[rd_addr];
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        next_base_next = next_base_reg;
        slice_next     = slice_reg;
        out_valid_next = out_valid_reg;
        if (cmd.pop || cmd.rotate)
            head_next = head_inc;
        if (cmd.append || cmd.scan_last || (cmd.scan_step && scan_last && !scan_hit))
            count_next = count_reg + CNT_W'(1);
        else if (cmd.pop)
            count_next = count_reg - CNT_W'(1);
        if (cmd.alloc)
        begin
            next_id_next   = next_id_reg + ID_W'(1);
            next_base_next = alloc_sum[BASE_W-1:0];
        end
        if (cmd.slice_inc)
            slice_next = slice_reg + SLICE_W'(1);
        else if (cmd.slice_clr)
            slice_next = '0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            next_id_reg   <= '0;
            next_base_reg <= '0;
            slice_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            next_base_reg <= next_base_next;
            slice_reg     <= slice_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_action_reg  <= action;
            item_size_reg    <= program_size;
            item_key_reg     <= job_length;
            res_new_id_reg   <= '0;
            res_base_reg     <= '0;
            res_err_reg      <= ERR_NONE;
            res_switched_reg <= 1'b0;
            res_stopped_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.alloc)
            begin
                res_new_id_reg <= next_id_reg;
                res_base_reg   <= base_ext[BASE_OUT_W-1:0];
            end
            if (cmd.err_we)
                res_err_reg <= cmd.err;
            if (cmd.set_switched)
                res_switched_reg <= 1'b1;
            if (cmd.set_stopped)
                res_stopped_reg <= 1'b1;
        end

        if (cmd.scan_init)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_inc;
            if (scan_hit)
            begin
                carry_reg <= rd_entry_reg;
                found_reg <= 1'b1;
            end
        end

        if (cmd.out_load)
        begin
            out_running_id_reg    <= cnt_zero ? '0 : rd_entry_reg.id;
            out_running_valid_reg <= !cnt_zero;
            out_switched_reg      <= res_switched_reg;
            out_stopped_reg       <= res_stopped_reg;
            out_new_id_reg        <= res_new_id_reg;
            out_base_reg          <= res_base_reg;
            out_error_reg         <= res_err_reg;
        end
    end

    assign status.act       = action_t'(item_action_reg);
    assign status.q_full    = (count_reg == MAX_CNT);
    assign status.mem_full  = (alloc_sum > MEM_LIMIT);
    assign status.cnt_zero  = cnt_zero;
    assign status.cnt_multi = (count_reg > CNT_W'(1));
    assign status.slice_le  = (slice_reg <= quantum);
    assign status.sjf       = (mode == MODE_SJF);
    assign status.rr        = (mode == MODE_RR);
    assign status.scan_hit  = scan_hit;
    assign status.scan_last = scan_last;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign running_id    = out_running_id_reg;
    assign running_valid = out_running_valid_reg;
    assign switched      = out_switched_reg;
    assign stopped       = out_stopped_reg;
    assign new_id        = out_new_id_reg;
    assign base_address  = out_base_reg;
    assign error         = out_error_reg;

endmodule

`default_nettype wire
